// File: src/lfu_pkg.sv
// Shared types, constants and width helpers for the LFU cache table.
package lfu_pkg;

  localparam int NUM_ENTRIES_DEF = 16;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int CAP_W           = 5;
  localparam int KEY_W           = 32;
  localparam int DATA_W          = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data_in;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] data_out;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
  } out_t;

  function automatic int idx_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // scan token: four flags, stored value, victim key, five index/rank fields, victim count
  function automatic int tok_bits(input int iw, input int cb);
    return 4 + DATA_W + KEY_W + 5 * iw + cb;
  endfunction

  // update broadcast: four flags, key, data, target and rank limit
  function automatic int upd_bits(input int iw);
    return 4 + KEY_W + DATA_W + 2 * iw;
  endfunction

endpackage

// File: src/lfu_cache_table.sv
// LFU cache table top level: request/result channels, capacity register, scan control.
//
// Usage:
//   in_valid/in_stall carry one request beat (get or put, key, data). out_valid/out_stall
//   carry one result beat per request (hit, data_out, evicted, evicted_key).
//   cfg_valid/cfg_ready write the capacity register; write it only while idle.
// Timing:
//   A request launches a token down the row of NUM_ENTRIES entry cells, one cell per cycle;
//   each cell folds in its key match, its bid for victim and its free-slot status.
//   The result beat is registered and the entry update is applied at the same clock edge,
//   which also returns the block to idle; only then is a new request taken, so one
//   request is in flight at a time and the length of the chain sets the request rate.
//   A result that waits under out_stall does not block the next request; a following
//   result waits until the held one is taken.
// Reset:
//   All entries become empty, occupancy clears, capacity returns to 16.
//   No clearing pass is needed; the block is ready in the cycle after reset.
module lfu_cache_table #(
  parameter int NUM_ENTRIES = lfu_pkg::NUM_ENTRIES_DEF,
  parameter int COUNT_BITS  = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  lfu_pkg::in_t              in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output lfu_pkg::out_t             out_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lfu_pkg::CAP_W-1:0] cfg_data
);

  localparam int IW   = lfu_pkg::idx_bits(NUM_ENTRIES);
  localparam int TW   = lfu_pkg::tok_bits(IW, COUNT_BITS);
  localparam int UW   = lfu_pkg::upd_bits(IW);
  localparam int OW   = $clog2(NUM_ENTRIES + 1);
  localparam int CMPW = (OW > lfu_pkg::CAP_W) ? OW : lfu_pkg::CAP_W;
  localparam logic [CMPW-1:0] N_CMP = CMPW'(NUM_ENTRIES);

  typedef struct packed {
    logic                       valid;
    logic                       hit;
    logic [IW-1:0]              hit_idx;
    logic [lfu_pkg::DATA_W-1:0] hit_val;
    logic [IW-1:0]              hit_rank;
    logic                       vic_ok;
    logic [IW-1:0]              vic_idx;
    logic [COUNT_BITS-1:0]      vic_cnt;
    logic [IW-1:0]              vic_rank;
    logic [lfu_pkg::KEY_W-1:0]  vic_key;
    logic                       free_ok;
    logic [IW-1:0]              free_idx;
  } tok_t;

  typedef struct packed {
    logic                       en;
    logic                       put;
    logic                       miss;
    logic                       lim_all;
    logic [IW-1:0]              tgt;
    logic [IW-1:0]              lim;
    logic [lfu_pkg::KEY_W-1:0]  key;
    logic [lfu_pkg::DATA_W-1:0] data;
  } upd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                     state;
  logic                       launch;
  lfu_pkg::op_t               qop;
  logic [lfu_pkg::KEY_W-1:0]  qkey;
  logic [lfu_pkg::DATA_W-1:0] qdata;
  tok_t                       fin;
  logic [OW-1:0]              occ;
  logic [lfu_pkg::CAP_W-1:0]  capacity;

  logic [TW-1:0]              chain [NUM_ENTRIES+1];
  tok_t                       head;
  tok_t                       last;
  upd_t                       u;
  lfu_pkg::out_t              res;
  logic                       ins;
  logic                       fire;
  logic [CMPW-1:0]            cap_w;
  logic [CMPW-1:0]            cap_eff;
  logic                       full;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    head       = '0;
    head.valid = launch;
  end

  assign chain[0] = TW'(head);
  assign last     = tok_t'(chain[NUM_ENTRIES]);

  for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
    lfu_cell #(
      .NUM_ENTRIES (NUM_ENTRIES),
      .COUNT_BITS  (COUNT_BITS),
      .CELL_ID     (i)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .qkey (qkey),
      .tin  (chain[i]),
      .tout (chain[i+1]),
      .upd  (UW'(u))
    );
  end

  assign cap_w   = CMPW'(capacity);
  assign cap_eff = (cap_w > N_CMP) ? N_CMP : cap_w;
  assign full    = (CMPW'(occ) >= cap_eff);
  assign fire    = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    res       = '0;
    u         = '0;
    u.key     = qkey;
    u.data    = qdata;
    ins       = 1'b0;
    if (cap_eff != '0) begin
      if (fin.hit) begin
        res.hit = 1'b1;
        if (qop == lfu_pkg::OP_GET) begin
          res.data_out = fin.hit_val;
        end
        u.en  = 1'b1;
        u.tgt = fin.hit_idx;
        u.lim = fin.hit_rank;
        u.put = (qop == lfu_pkg::OP_PUT);
      end else if (qop == lfu_pkg::OP_PUT) begin
        if (full) begin
          if (fin.vic_ok) begin
            res.evicted     = 1'b1;
            res.evicted_key = fin.vic_key;
            u.en   = 1'b1;
            u.tgt  = fin.vic_idx;
            u.lim  = fin.vic_rank;
            u.put  = 1'b1;
            u.miss = 1'b1;
          end
        end else if (fin.free_ok) begin
          u.en      = 1'b1;
          u.tgt     = fin.free_idx;
          u.lim_all = 1'b1;
          u.put     = 1'b1;
          u.miss    = 1'b1;
          ins       = 1'b1;
        end
      end
    end
    u.en = u.en && fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launch    <= 1'b0;
      occ       <= '0;
      capacity  <= lfu_pkg::CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      launch <= (state == S_IDLE) && in_valid;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (out_valid && !out_stall && !fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            qop    <= in_item.op;
            qkey   <= in_item.key;
            qdata  <= in_item.data_in;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (last.valid) begin
            fin   <= last;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (fire) begin
            out_valid <= 1'b1;
            out_item  <= res;
            if (ins) begin
              occ <= occ + OW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_scan_end_in_scan: assert property (@(posedge clk) disable iff (rst)
    last.valid |-> (state == S_SCAN))
    else $error("scan token left the chain outside the scan phase");

  a_update_in_done: assert property (@(posedge clk) disable iff (rst)
    u.en |-> (state == S_DONE) && !(out_valid && out_stall))
    else $error("entry update issued without a result slot");

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    CMPW'(occ) <= N_CMP)
    else $error("occupancy exceeds entry count");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> launch && (state == S_SCAN))
    else $error("accepted request did not launch a scan");

  a_insert_needs_room: assert property (@(posedge clk) disable iff (rst)
    (fire && ins) |-> (CMPW'(occ) < cap_eff))
    else $error("insert into a full table");

endmodule

// File: src/lfu_cell.sv
// One cache entry: key/value/count/rank storage plus one registered stage of the scan chain.
module lfu_cell #(
  parameter int NUM_ENTRIES = lfu_pkg::NUM_ENTRIES_DEF,
  parameter int COUNT_BITS  = lfu_pkg::COUNT_BITS_DEF,
  parameter int CELL_ID     = 0,
  localparam int IW = lfu_pkg::idx_bits(NUM_ENTRIES),
  localparam int TW = lfu_pkg::tok_bits(IW, COUNT_BITS),
  localparam int UW = lfu_pkg::upd_bits(IW)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [lfu_pkg::KEY_W-1:0]  qkey,
  input  logic [TW-1:0]              tin,
  output logic [TW-1:0]              tout,
  input  logic [UW-1:0]              upd
);

  typedef struct packed {
    logic                       valid;
    logic                       hit;
    logic [IW-1:0]              hit_idx;
    logic [lfu_pkg::DATA_W-1:0] hit_val;
    logic [IW-1:0]              hit_rank;
    logic                       vic_ok;
    logic [IW-1:0]              vic_idx;
    logic [COUNT_BITS-1:0]      vic_cnt;
    logic [IW-1:0]              vic_rank;
    logic [lfu_pkg::KEY_W-1:0]  vic_key;
    logic                       free_ok;
    logic [IW-1:0]              free_idx;
  } tok_t;

  typedef struct packed {
    logic                       en;
    logic                       put;
    logic                       miss;
    logic                       lim_all;
    logic [IW-1:0]              tgt;
    logic [IW-1:0]              lim;
    logic [lfu_pkg::KEY_W-1:0]  key;
    logic [lfu_pkg::DATA_W-1:0] data;
  } upd_t;

  localparam logic [IW-1:0] MY_IDX = IW'(CELL_ID);

  logic                       valid;
  logic [lfu_pkg::KEY_W-1:0]  key_r;
  logic [lfu_pkg::DATA_W-1:0] val_r;
  logic [COUNT_BITS-1:0]      cnt;
  logic [IW-1:0]              rank;
  tok_t                       ti;
  tok_t                       tn;
  tok_t                       tok_r;
  upd_t                       u;
  logic                       me;

  assign ti   = tok_t'(tin);
  assign u    = upd_t'(upd);
  assign tout = TW'(tok_r);
  assign me   = (u.tgt == MY_IDX);

  always_comb begin
    tn = ti;
    if (!ti.hit && valid && (key_r == qkey)) begin
      tn.hit      = 1'b1;
      tn.hit_idx  = MY_IDX;
      tn.hit_val  = val_r;
      tn.hit_rank = rank;
    end
    if (valid && (!ti.vic_ok || (cnt < ti.vic_cnt) ||
                  ((cnt == ti.vic_cnt) && (rank > ti.vic_rank)))) begin
      tn.vic_ok   = 1'b1;
      tn.vic_idx  = MY_IDX;
      tn.vic_cnt  = cnt;
      tn.vic_rank = rank;
      tn.vic_key  = key_r;
    end
    if (!valid && !ti.free_ok) begin
      tn.free_ok  = 1'b1;
      tn.free_idx = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      tok_r <= '0;
    end else begin
      tok_r <= tn;
      if (u.en && me) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (u.en) begin
      if (me) begin
        rank <= '0;
        if (u.put) begin
          val_r <= u.data;
        end
        if (u.miss) begin
          key_r <= u.key;
          cnt   <= COUNT_BITS'(1);
        end else if (cnt != '1) begin
          cnt <= cnt + COUNT_BITS'(1);
        end
      end else if (valid && (u.lim_all || (rank < u.lim))) begin
        rank <= rank + IW'(1);
      end
    end
  end

endmodule

// File: tb/sv/lfu_cache_table_test.sv
// Self-checking testbench for lfu_cache_table: directed table, random get/put traffic, capacity sweep.
module lfu_cache_table_test;
  import lfu_pkg::*;

  localparam int NE = NUM_ENTRIES_DEF;
  localparam longint unsigned HITS_MAX = (64'd1 << COUNT_BITS_DEF) - 1;
  localparam int SPAN = NE + 3;
  localparam int IDLE_LIMIT = 1000;
  localparam int PLAN_LEN = 23;
  localparam int POOL = 24;
  localparam int PHASES = 8;
  localparam out_t MISS = '0;

  typedef enum {ROW_REQ, ROW_CAP} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [CAP_W-1:0]  cap;
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    bit                fixed;
    out_t              want;
  } plan_row_t;

  typedef struct {
    in_t  req;
    bit   fixed;
    out_t want;
  } pending_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_t              in_item = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_t             out_item;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;

  lfu_cache_table i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // cache image kept alongside the block
  bit                slot_used [NE];
  logic [KEY_W-1:0]  slot_key  [NE];
  logic [DATA_W-1:0] slot_val  [NE];
  longint unsigned   slot_hits [NE];
  int unsigned       slot_age  [NE];
  int unsigned       fill = 0;
  logic [CAP_W-1:0]  cap_reg = CAP_RESET;

  pending_t request_queue [$];
  out_t     awaited_results [$];

  bit       calm = 1'b0;
  int       gap_left = 0;
  int       hold_left = 0;
  int       idle_cycles = 0;
  int       bad = 0;
  int       n_req = 0;
  int       n_res = 0;
  int       n_hit = 0;
  int       n_evict = 0;
  int       n_cfg = 0;
  pending_t head;
  out_t     guess;
  out_t     want;

  logic [KEY_W-1:0] key_pool [POOL];
  int phase_cap [PHASES] = '{16, 4, 1, 0, 31, 7, 2, 16};
  int phase_len [PHASES] = '{200, 200, 200, 40, 200, 200, 200, 200};

  plan_row_t plan [PLAN_LEN] = '{
    '{ROW_REQ, 5'd0,  OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, MISS},
    '{ROW_REQ, 5'd0,  OP_PUT, 32'h0000_0000, 32'hffff_ffff, 1'b1, MISS},
    '{ROW_REQ, 5'd0,  OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{1'b1, 32'hffff_ffff, 1'b0, 32'h0}},
    '{ROW_REQ, 5'd0,  OP_PUT, 32'hffff_ffff, 32'h0000_0000, 1'b1, MISS},
    '{ROW_REQ, 5'd0,  OP_GET, 32'hffff_ffff, 32'haaaa_aaaa, 1'b1,
      '{1'b1, 32'h0, 1'b0, 32'h0}},
    '{ROW_REQ, 5'd0,  OP_PUT, 32'h0000_0000, 32'h1234_5678, 1'b1,
      '{1'b1, 32'h0, 1'b0, 32'h0}},
    '{ROW_CAP, 5'd0,  OP_GET, 32'h0, 32'h0, 1'b0, MISS},
    '{ROW_REQ, 5'd0,  OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, MISS},
    '{ROW_REQ, 5'd0,  OP_PUT, 32'h0000_0055, 32'h5555_5555, 1'b1, MISS},
    '{ROW_CAP, 5'd31, OP_GET, 32'h0, 32'h0, 1'b0, MISS},
    '{ROW_REQ, 5'd0,  OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{1'b1, 32'h1234_5678, 1'b0, 32'h0}},
    '{ROW_REQ, 5'd0,  OP_GET, 32'h0000_0055, 32'h0000_0000, 1'b1, MISS},
    '{ROW_CAP, 5'd2,  OP_GET, 32'h0, 32'h0, 1'b0, MISS},
    '{ROW_REQ, 5'd0,  OP_PUT, 32'h0000_0007, 32'h0000_0007, 1'b0, MISS},
    '{ROW_REQ, 5'd0,  OP_PUT, 32'h0000_0008, 32'h0000_0008, 1'b0, MISS},
    '{ROW_CAP, 5'd1,  OP_GET, 32'h0, 32'h0, 1'b0, MISS},
    '{ROW_REQ, 5'd0,  OP_PUT, 32'h0000_0009, 32'h0000_0009, 1'b0, MISS},
    '{ROW_REQ, 5'd0,  OP_GET, 32'h0000_0008, 32'h0000_0000, 1'b0, MISS},
    '{ROW_CAP, 5'd3,  OP_GET, 32'h0, 32'h0, 1'b0, MISS},
    '{ROW_REQ, 5'd0,  OP_PUT, 32'h0000_000a, 32'h0000_000a, 1'b0, MISS},
    '{ROW_REQ, 5'd0,  OP_PUT, 32'h0000_000b, 32'h0000_000b, 1'b0, MISS},
    '{ROW_REQ, 5'd0,  OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, MISS},
    '{ROW_CAP, 5'd16, OP_GET, 32'h0, 32'h0, 1'b0, MISS}
  };

  function automatic int draw_gap();
    return calm ? 0 : int'($urandom_range(0, 6));
  endfunction

  function automatic void make_recent(input int s, input int unsigned limit);
    for (int i = 0; i < NE; i++)
      if (slot_used[i] && i != s && slot_age[i] < limit) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function automatic out_t cache_access(input in_t req);
    out_t        r;
    int unsigned lim;
    int          hit_at;
    int          victim;
    r = '0;
    lim = (cap_reg > NE) ? NE : cap_reg;
    hit_at = -1;
    victim = -1;
    if (lim == 0) return r;
    for (int i = 0; i < NE; i++)
      if (hit_at < 0 && slot_used[i] && slot_key[i] == req.key) hit_at = i;
    if (hit_at >= 0) begin
      r.hit = 1'b1;
      if (req.op == OP_GET) r.data_out = slot_val[hit_at];
      else slot_val[hit_at] = req.data_in;
      if (slot_hits[hit_at] < HITS_MAX) slot_hits[hit_at]++;
      make_recent(hit_at, slot_age[hit_at]);
      return r;
    end
    if (req.op == OP_GET) return r;
    if (fill >= lim) begin
      // lowest count, oldest among equals
      for (int i = 0; i < NE; i++)
        if (slot_used[i] && (victim < 0 || slot_hits[i] < slot_hits[victim] ||
            (slot_hits[i] == slot_hits[victim] && slot_age[i] > slot_age[victim])))
          victim = i;
      r.evicted = 1'b1;
      r.evicted_key = slot_key[victim];
    end else begin
      for (int i = 0; i < NE; i++)
        if (victim < 0 && !slot_used[i]) victim = i;
      slot_used[victim] = 1'b1;
      fill++;
    end
    slot_key[victim] = req.key;
    slot_val[victim] = req.data_in;
    slot_hits[victim] = 1;
    make_recent(victim, r.evicted ? slot_age[victim] : 32'hffff_ffff);
    return r;
  endfunction

  // request side
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        head = request_queue.pop_front();
        guess = cache_access(in_item);
        awaited_results.push_back(head.fixed ? head.want : guess);
        n_req++;
        gap_left = draw_gap();
      end else if (!in_valid && gap_left != 0) begin
        gap_left--;
      end
      if (request_queue.size() != 0 && gap_left == 0) begin
        in_valid <= 1'b1;
        in_item <= request_queue[0].req;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_res++;
        if (awaited_results.size() == 0) begin
          bad++;
          if (bad <= 10)
            $display("result %0d with nothing outstanding: hit=%0b data=%h evicted=%0b key=%h",
                     n_res, out_item.hit, out_item.data_out, out_item.evicted,
                     out_item.evicted_key);
        end else begin
          want = awaited_results.pop_front();
          if (out_item.hit !== want.hit || out_item.data_out !== want.data_out ||
              out_item.evicted !== want.evicted || out_item.evicted_key !== want.evicted_key)
          begin
            bad++;
            if (bad <= 10)
              $display("result %0d: expected hit=%0b data=%h evicted=%0b key=%h, %s%0b %s%h %s%0b %s%h",
                       n_res, want.hit, want.data_out, want.evicted, want.evicted_key,
                       "got hit=", out_item.hit, "data=", out_item.data_out,
                       "evicted=", out_item.evicted, "key=", out_item.evicted_key);
          end
          n_hit += want.hit;
          n_evict += want.evicted;
        end
        hold_left = draw_gap();
      end else if (out_valid && hold_left != 0) begin
        hold_left--;
      end
      out_stall <= (hold_left != 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("lfu_cache_table_test: errors");
        $finish;
      end
    end
  end

  task automatic drain();
    do @(negedge clk);
    while (request_queue.size() != 0 || awaited_results.size() != 0);
    @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_reg = value;
    n_cfg++;
  endtask

  task automatic queue_request(input pending_t p);
    @(negedge clk);
    while (request_queue.size() > 1) @(negedge clk);
    request_queue.push_back(p);
  endtask

  // use-count saturation needs 64K hits on one entry; not reached in this run
  initial begin
    pending_t   p;
    int unsigned u;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hffff_ffff;
    for (int i = 2; i < POOL; i++) key_pool[i] = $urandom;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < PLAN_LEN; r++) begin
      if (plan[r].kind == ROW_CAP) begin
        set_capacity(plan[r].cap);
      end else begin
        p.req.op = plan[r].op;
        p.req.key = plan[r].key;
        p.req.data_in = plan[r].data;
        p.fixed = plan[r].fixed;
        p.want = plan[r].want;
        queue_request(p);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      set_capacity(phase_cap[ph][CAP_W-1:0]);
      for (int n = 0; n < phase_len[ph]; n++) begin
        if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        u = $urandom_range(0, 19);
        if (u < 2) p.req.key = $urandom;
        else if (u < 12) p.req.key = key_pool[$urandom_range(0, 5)];
        else p.req.key = key_pool[$urandom_range(0, POOL - 1)];
        p.req.op = $urandom_range(0, 1) ? OP_PUT : OP_GET;
        p.req.data_in = $urandom;
        p.fixed = 1'b0;
        p.want = MISS;
        queue_request(p);
      end
    end

    drain();
    repeat (SPAN) @(posedge clk);
    bad += awaited_results.size();
    $display("%0d requests across %0d capacity writes (0, 1, 2, 3, 4, 7, 16 and 31)",
             n_req, n_cfg);
    $display("%0d hits, %0d evictions, %0d mismatches", n_hit, n_evict, bad);
    if (bad == 0) begin
      $display("lfu_cache_table_test: clean");
    end else begin
      $display("lfu_cache_table_test: errors");
    end
    $finish;
  end

endmodule
